// ===== rtl/core/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, register indexes and bound precompute for the LSB embedder.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PASS_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_W0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_W1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_WORD = 3'd5;

  // Input transaction kinds
  typedef enum logic {OP_LOAD = 1'b0, OP_COVER = 1'b1} lse_op_t;

  localparam logic [4:0]  PASS_MAX    = 5'd16;
  localparam logic [31:0] SIG_BYTES   = 32'd56;
  localparam logic [5:0]  SIG_TOP_BIT = 6'd55;
  localparam logic [7:0]  LEN_FIELD   = 8'd32;
  localparam logic [7:0]  LSB_CLEAR   = 8'hFE;

  // Reset values of the registers
  localparam logic [30:0] RST_MSG_LEN  = 31'd1;
  localparam logic [31:0] RST_IMG_LEN  = 32'd1;
  localparam logic [55:0] RST_SIG_WORD = 56'h4D696B6861696C;

  // Register contents plus bounds derived from them at write time
  typedef struct packed {
    logic [127:0] pw;         // password bytes, byte 0 in the top bits
    logic [55:0]  sig;        // signature bits, first byte on top
    logic [30:0]  msg_len;
    logic [31:0]  img_len;
    logic [4:0]   pw_len;     // already clamped to PASS_MAX
    logic [7:0]   pass_end;   // first position of the length field
    logic [7:0]   len_end;    // first position of the message bits
    logic [33:0]  msg_end;    // first position after the payload
    logic [31:0]  sig_start;  // first position of the signature
    logic         sig_en;     // image long enough to hold a signature
    logic [31:0]  last_pos;
    logic         ovf;        // payload does not fit in the image
  } lse_cfg_t;

  // One embedding result
  typedef struct packed {
    logic [7:0]  stego;
    logic        last;
    logic        ovf;
    logic [31:0] pos_nxt;
  } lse_res_t;

  // Fill the derived bounds from the raw register fields
  function automatic lse_cfg_t lse_derive(input lse_cfg_t c);
    lse_cfg_t d;
    d           = c;
    d.pass_end  = {c.pw_len + 5'd1, 3'b000};
    d.len_end   = d.pass_end + LEN_FIELD;
    d.msg_end   = 34'(d.len_end) + {c.msg_len, 3'b000};
    d.sig_start = c.img_len - SIG_BYTES;
    d.sig_en    = (c.img_len >= SIG_BYTES);
    d.last_pos  = c.img_len - 32'd1;
    d.ovf       = (d.msg_end > {2'b00, c.img_len});
    return d;
  endfunction

endpackage

// ===== rtl/core/lse_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lse_cfg_regs
// Configuration register file; recomputes payload and signature bounds on
// every write so the datapath only compares.
// ----------------------------------------------------------------------------
module lse_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [lse_pkg::CFG_DATA_W-1:0] wr_data,
  output lse_pkg::lse_cfg_t              cfg
);
  import lse_pkg::*;

  lse_cfg_t cfg_r;
  lse_cfg_t raw_nxt;
  lse_cfg_t cfg_nxt;
  lse_cfg_t cfg_rst;

  // Reset contents with their bounds
  always_comb begin
    cfg_rst          = '0;
    cfg_rst.msg_len  = RST_MSG_LEN;
    cfg_rst.img_len  = RST_IMG_LEN;
    cfg_rst.sig      = RST_SIG_WORD;
    cfg_rst          = lse_derive(cfg_rst);
  end

  // Decode the write and refresh the bounds
  always_comb begin
    raw_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_PASS_LEN: begin
          raw_nxt.pw_len = (wr_data[4:0] > PASS_MAX) ? PASS_MAX : wr_data[4:0];
        end
        REG_PASS_W0:  raw_nxt.pw[127:64] = wr_data;
        REG_PASS_W1:  raw_nxt.pw[63:0]   = wr_data;
        REG_MSG_LEN:  raw_nxt.msg_len    = wr_data[30:0];
        REG_IMG_LEN:  raw_nxt.img_len    = wr_data[31:0];
        REG_SIG_WORD: raw_nxt.sig        = wr_data[55:0];
        default: ;
      endcase
    end
    cfg_nxt = lse_derive(raw_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/lse_embed.sv =====
// ----------------------------------------------------------------------------
// lse_embed
// Per-byte datapath: picks the payload or signature bit for the current
// position and flags the last byte of the image.
// ----------------------------------------------------------------------------
module lse_embed (
  input  lse_pkg::lse_cfg_t cfg,
  input  logic [31:0]       pos,
  input  logic [7:0]        cover_byte,
  input  logic [7:0]        held_msg,
  output lse_pkg::lse_res_t res
);
  import lse_pkg::*;

  logic [7:0]  pl8;
  logic [31:0] ml32;
  logic [6:0]  q;
  logic [4:0]  r;
  logic [5:0]  sidx;
  logic        in_len_byte;
  logic        in_pass;
  logic        in_len;
  logic        in_msg;
  logic        in_sig;
  logic        pbit;
  logic        sbit;
  logic        last;

  always_comb begin
    pl8  = {3'b000, cfg.pw_len};
    ml32 = {1'b0, cfg.msg_len};
    // Offsets inside each field; the password and length fields start on multiples of eight
    q    = pos[6:0] - 7'd8;
    r    = pos[4:0] - cfg.pass_end[4:0];
    sidx = SIG_TOP_BIT - (pos[5:0] - cfg.sig_start[5:0]);

    in_len_byte = (pos[31:3] == '0);
    in_pass     = (pos < 32'(cfg.pass_end));
    in_len      = (pos < 32'(cfg.len_end));
    in_msg      = ({2'b00, pos} < cfg.msg_end);
    in_sig      = cfg.sig_en && (pos < cfg.img_len) && (pos >= cfg.sig_start);

    // Payload bit, most significant bit of each field first
    if (in_len_byte) begin
      pbit = pl8[~pos[2:0]];
    end else if (in_pass) begin
      pbit = cfg.pw[~q];
    end else if (in_len) begin
      pbit = ml32[~r];
    end else begin
      pbit = held_msg[~pos[2:0]];
    end
    sbit = cfg.sig[sidx];

    // Signature overrides the payload
    if (in_sig) begin
      res.stego = (cover_byte & LSB_CLEAR) | {7'd0, sbit};
    end else if (in_msg) begin
      res.stego = (cover_byte & LSB_CLEAR) | {7'd0, pbit};
    end else begin
      res.stego = cover_byte;
    end

    last        = (pos == cfg.last_pos);
    res.last    = last;
    res.ovf     = last && cfg.ovf;
    res.pos_nxt = last ? 32'd0 : pos + 32'd1;
  end

endmodule

// ===== rtl/core/lsb_stego_embedder.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_embedder
// Streams cover bytes and embeds a password/message payload and a trailing
// signature in their least significant bits.
// ----------------------------------------------------------------------------
// One transaction per clock while results drain: an input register feeds a
// single compare-and-select stage into an output register, so cover bytes and
// message loads both sustain one per cycle while the result channel takes its
// output. The per-byte path is a handful of position compares against bounds
// that the configuration block precomputes on every register write. Load
// each message byte ahead of its eight cover bytes. The input keeps
// accepting while a result waits, until both stages are full.
module lsb_stego_embedder (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [7:0] cover_byte, [15:8] message_byte
  input  logic                           in_tuser,   // [0] operation
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] stego_byte
  output logic                           out_tlast,  // last_byte
  output logic                           out_tuser,  // [0] overflow
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lse_pkg::*;

  lse_cfg_t    cfg;
  lse_res_t    res;

  logic        s1_v_r;
  logic        s1_op_r;
  logic [7:0]  s1_cover_r;
  logic [7:0]  s1_msg_r;
  logic [31:0] pos_r;
  logic [7:0]  held_r;
  logic        out_v_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_ovf_r;
  logic        s1_adv;
  logic        s1_emit;

  assign cfg_ready = 1'b1;

  lse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  lse_embed u_embed (
    .cfg        (cfg),
    .pos        (pos_r),
    .cover_byte (s1_cover_r),
    .held_msg   (held_r),
    .res        (res)
  );

  // Advance the input stage; loads never need the output slot
  assign s1_emit   = s1_v_r && (s1_op_r != OP_LOAD);
  assign s1_adv    = s1_v_r && ((s1_op_r == OP_LOAD) || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pos_r   <= '0;
      held_r  <= '0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_adv && s1_emit) begin
        out_v_r <= 1'b1;
        pos_r   <= res.pos_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (s1_adv && !s1_emit) begin
        held_r <= s1_msg_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= in_tuser;
      s1_cover_r <= in_tdata[7:0];
      s1_msg_r   <= in_tdata[15:8];
    end
    if (s1_adv && s1_emit) begin
      out_byte_r <= res.stego;
      out_last_r <= res.last;
      out_ovf_r  <= res.ovf;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

`ifndef SYNTH
  // Overflow is only ever reported on the last byte
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("overflow flagged off the last byte");

  // Position restarts after the last byte
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emit && res.last) |=> (pos_r == 32'd0))
    else $error("position did not restart after last byte");

  // Position steps by one on every cover byte but the last
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emit && !res.last) |=> (pos_r == 32'($past(pos_r) + 32'd1)))
    else $error("position did not advance");

  // Message loads leave the position alone
  a_load_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_emit) |=> $stable(pos_r))
    else $error("message load moved the position");
`endif

endmodule
